@@ hdl/gte_pkg.sv @@
// shared types, codes and constants of the grant table engine
`timescale 1ns / 1ps

package gte_pkg;

    localparam int DEF_TABLE_SIZE = 64;

    localparam int FUNC_W    = 3;
    localparam int GID_W     = 8;
    localparam int EP_W      = 32;
    localparam int ADDR_W    = 32;
    localparam int ACCESS_W  = 4;
    localparam int STATUS_W  = 2;
    localparam int RESULT_W  = 9;
    localparam int KIND_W    = 2;
    localparam int S_DATA_W  = 176;
    localparam int M_DATA_W  = 80;

    localparam logic [FUNC_W-1:0] FN_DIRECT   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INDIRECT = 3'd1;
    localparam logic [FUNC_W-1:0] FN_MAGIC    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_REVOKE   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_LOOKUP   = 3'd4;

    localparam logic [KIND_W-1:0] KIND_DIRECT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INDIRECT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_MAGIC    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOSPACE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOLOOKUP = 2'd3;

    localparam logic [RESULT_W-1:0] RESULT_NONE = 9'h1FF;

    // memory word: kind, source endpoint, target endpoint
    localparam int SLOT_W = KIND_W + 2 * EP_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_OUT
    } t_state;

endpackage

@@ hdl/grant_table_engine_core.sv @@
// grant table engine top level: request decode, slot allocation and result register
//
//  channel   | direction | transaction
//  s (i_s_*) | in        | one request: tuser func, tdata operands
//  m (o_m_*) | out       | one response: tuser status, tdata slot, granter, grantee
//  cfg       | in        | write of self_endpoint
//
// grant and revoke go from S_IDLE straight to S_OUT, lookup passes through S_LOOK (one slot memory read)
// lowest free slot comes from a registered priority encoder over the used bits
// one request at a time; the next is taken once the response has left
// reset is synchronous: all slots free, self_endpoint zero, no memory clearing
// a stalled response holds in the output register until i_m_tready
`timescale 1ns / 1ps

module grant_table_engine_core import gte_pkg::*; #(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [EP_W-1:0]     i_cfg_wdata,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // grant_id[7:0], who_to[39:8], source_ep[71:40], start_address[103:72],
    // byte_count[135:104], access_rights[139:136], parent_grant[171:140]
    input  logic [S_DATA_W-1:0] i_s_tdata,
    // func[2:0]
    input  logic [FUNC_W-1:0]   i_s_tuser,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // result_grant[8:0], granter[40:9], grantee[72:41]
    output logic [M_DATA_W-1:0] o_m_tdata,
    // status[1:0]
    output logic [STATUS_W-1:0] o_m_tuser
);

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int IW = ((AW > GID_W) ? AW : GID_W) + 1;

    t_state r_state, n_state;

    logic signed [EP_W-1:0]   r_self_endpoint;
    logic [TABLE_SIZE-1:0]    r_used, n_used;
    logic [AW-1:0]            r_free, n_free;
    logic                     r_full, n_full;

    logic [STATUS_W-1:0]      r_status, n_status;
    logic [RESULT_W-1:0]      r_result, n_result;
    logic [EP_W-1:0]          r_granter, n_granter;
    logic [EP_W-1:0]          r_grantee, n_grantee;
    logic                     r_look_ok, n_look_ok;

    logic [FUNC_W-1:0]        w_func;
    logic [GID_W-1:0]         w_gid;
    logic [EP_W-1:0]          w_who_to;
    logic [EP_W-1:0]          w_src_ep;
    logic [ACCESS_W-1:0]      w_access;
    logic [IW-1:0]            w_gid_ext;
    logic [AW-1:0]            w_gid_addr;
    logic                     w_gid_used;
    logic                     w_bad_access;

    logic                     w_we;
    logic [SLOT_W-1:0]        w_wdata;
    logic [SLOT_W-1:0]        w_rdata;
    logic [KIND_W-1:0]        w_rd_kind;
    logic [EP_W-1:0]          w_rd_source;
    logic [EP_W-1:0]          w_rd_target;

    assign w_func       = i_s_tuser;
    assign w_gid        = i_s_tdata[7:0];
    assign w_who_to     = i_s_tdata[39:8];
    assign w_src_ep     = i_s_tdata[71:40];
    assign w_access     = i_s_tdata[139:136];
    assign w_gid_ext    = IW'(w_gid);
    assign w_gid_addr   = w_gid_ext[AW-1:0];
    assign w_gid_used   = (w_gid_ext < IW'(TABLE_SIZE)) && r_used[w_gid_addr];
    assign w_bad_access = (w_access[3:2] != 2'b00);

    assign w_rd_target  = w_rdata[EP_W-1:0];
    assign w_rd_source  = w_rdata[2*EP_W-1:EP_W];
    assign w_rd_kind    = w_rdata[SLOT_W-1:2*EP_W];

    gte_slot_ram #(
        .TABLE_SIZE (TABLE_SIZE),
        .AW         (AW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_free),
        .i_wdata (w_wdata),
        .i_raddr (w_gid_addr),
        .o_rdata (w_rdata)
    );

    // lowest free slot
    always_comb begin
        n_free = '0;
        n_full = 1'b1;
        for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                n_free = AW'(i);
                n_full = 1'b0;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_used    = r_used;
        n_status  = r_status;
        n_result  = r_result;
        n_granter = r_granter;
        n_grantee = r_grantee;
        n_look_ok = r_look_ok;
        w_we      = 1'b0;
        w_wdata   = {KIND_DIRECT, w_src_ep, w_who_to};
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_status  = ST_INVALID;
                    n_result  = RESULT_NONE;
                    n_granter = '0;
                    n_grantee = '0;
                    n_state   = S_OUT;
                    case (w_func)
                        FN_DIRECT, FN_INDIRECT, FN_MAGIC: begin
                            if (w_func == FN_MAGIC && w_bad_access) begin
                                n_status = ST_INVALID;
                            end else if (r_full) begin
                                n_status = ST_NOSPACE;
                            end else if (w_func == FN_DIRECT && w_bad_access) begin
                                n_status = ST_INVALID;
                            end else begin
                                w_we           = 1'b1;
                                n_used[r_free] = 1'b1;
                                n_status       = ST_OK;
                                n_result       = RESULT_W'(r_free);
                                if (w_func == FN_INDIRECT) begin
                                    w_wdata = {KIND_INDIRECT, w_src_ep, w_who_to};
                                end else if (w_func == FN_MAGIC) begin
                                    w_wdata = {KIND_MAGIC, w_src_ep, w_who_to};
                                end
                            end
                        end
                        FN_REVOKE: begin
                            if (w_gid_used) begin
                                n_used[w_gid_addr] = 1'b0;
                                n_status           = ST_OK;
                            end
                        end
                        FN_LOOKUP: begin
                            n_look_ok = w_gid_used;
                            n_state   = S_LOOK;
                        end
                        default: begin
                            n_status = ST_INVALID;
                        end
                    endcase
                end
            end
            S_LOOK: begin
                n_state = S_OUT;
                if (r_look_ok) begin
                    if (w_rd_kind == KIND_DIRECT) begin
                        n_status  = ST_OK;
                        n_granter = r_self_endpoint;
                        n_grantee = w_rd_target;
                    end else if (w_rd_kind == KIND_MAGIC) begin
                        n_status  = ST_OK;
                        n_granter = w_rd_source;
                        n_grantee = w_rd_target;
                    end else begin
                        n_status = ST_NOLOOKUP;
                    end
                end
            end
            S_OUT: begin
                if (i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_used          <= '0;
            r_free          <= '0;
            r_full          <= 1'b0;
            r_self_endpoint <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_free  <= n_free;
            r_full  <= n_full;
            if (i_cfg_we) begin
                r_self_endpoint <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_result  <= n_result;
        r_granter <= n_granter;
        r_grantee <= n_grantee;
        r_look_ok <= n_look_ok;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = (r_state == S_OUT);
    assign o_m_tdata  = {7'd0, r_grantee, r_granter, r_result};
    assign o_m_tuser  = r_status;

endmodule

@@ hdl/gte_slot_ram.sv @@
// slot memory, one write port and one read port with registered read data
`timescale 1ns / 1ps

module gte_slot_ram import gte_pkg::*; #(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE,
    parameter int AW         = $clog2(TABLE_SIZE)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [SLOT_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [SLOT_W-1:0] o_rdata
);

    logic [SLOT_W-1:0] r_mem [TABLE_SIZE];
    logic [SLOT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
